/* sv/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the bank mapper
// op codes, target codes, register decode values and the structs that pass
// between the mapper's control and translation logic
// ----------------------------------------------------------------------------
package cbm_pkg;

	// fixed geometry of the mapper
	localparam int CHR_SLOTS   = 8;
	localparam int PRG_WINDOWS = 4;
	localparam int CFG_INDEX_W = 2;

	// bus operation codes
	typedef enum logic [1:0] {
		OP_CPU_WR = 2'd0,
		OP_CPU_RD = 2'd1,
		OP_PPU    = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	// target memory codes
	localparam logic [3:0] TGT_PRG       = 4'd0;
	localparam logic [3:0] TGT_CHR_ROM   = 4'd1;
	localparam logic [3:0] TGT_CHR_RAM   = 4'd2;
	localparam logic [3:0] TGT_MAIN_WRAM = 4'd3;
	localparam logic [3:0] TGT_PAGE0     = 4'd4;
	localparam logic [3:0] TGT_NONE      = 4'd8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PRG_MASK  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_MASK  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_IS_RAM = 2'd2;

	// mapper register decode, address and 0xE001
	localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRROR      = 16'hA000;
	localparam logic [15:0] REG_WRAM_CTRL   = 16'hA001;
	localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;

	// bank select nibble codes
	localparam logic [3:0] SEL_CHR_PAIR_A = 4'h0;
	localparam logic [3:0] SEL_CHR_PAIR_B = 4'h1;
	localparam logic [3:0] SEL_CHR_4      = 4'h2;
	localparam logic [3:0] SEL_CHR_5      = 4'h3;
	localparam logic [3:0] SEL_CHR_6      = 4'h4;
	localparam logic [3:0] SEL_CHR_7      = 4'h5;
	localparam logic [3:0] SEL_PRG_0      = 4'h6;
	localparam logic [3:0] SEL_PRG_1      = 4'h7;
	localparam logic [3:0] SEL_PRG_2      = 4'h8;
	localparam logic [3:0] SEL_PRG_3      = 4'h9;
	localparam logic [3:0] SEL_CHR_1      = 4'hA;
	localparam logic [3:0] SEL_CHR_3      = 4'hB;

	localparam logic [7:0] SEL_PRG_SWAP = 8'h40;
	localparam logic [7:0] SEL_CHR_SWAP = 8'h80;
	localparam logic [7:0] WRAM_SEL_MASK = 8'hE3;
	localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

	// reset values
	localparam logic [7:0] PRG_MASK_RST = 8'd63;
	localparam logic [7:0] CHR_MASK_RST = 8'd255;

	// one input transaction
	typedef struct packed {
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [8:0]  scanline;
		logic        display_on;
	} cbm_item_t;

	// one result transaction
	typedef struct packed {
		logic [3:0]  target;
		logic [20:0] mapped_addr;
		logic        also_main_wram;
		logic [1:0]  mirror_mode;
		logic        irq_line;
	} cbm_result_t;

	// control state seen by the translation logic
	typedef struct packed {
		logic [7:0] bank_select;
		logic [7:0] wram_ctrl;
		logic       chr_is_ram;
		logic [7:0] prg_mask;
		logic [7:0] chr_mask;
		logic [1:0] mirror_next;
		logic       irq_next;
	} cbm_ctrl_t;

endpackage

/* sv/cbm_if.sv */
// ----------------------------------------------------------------------------
// cbm_in_if / cbm_out_if: valid/ready channels of the bank mapper
// bus events in, translated results out
// ----------------------------------------------------------------------------
interface cbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] addr;
	logic [7:0]  data;
	logic [8:0]  scanline;
	logic        display_on;

	modport source (output valid, op, addr, data, scanline, display_on, input ready);
	modport sink (input valid, op, addr, data, scanline, display_on, output ready);
endinterface

interface cbm_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  target;
	logic [20:0] mapped_addr;
	logic        also_main_wram;
	logic [1:0]  mirror_mode;
	logic        irq_line;

	modport source (output valid, target, mapped_addr, also_main_wram, mirror_mode, irq_line,
		input ready);
	modport sink (input valid, target, mapped_addr, also_main_wram, mirror_mode, irq_line,
		output ready);
endinterface

/* sv/cartridge_bank_mapper_scanline_irq.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq: bank mapper with scanline interrupt
// translates CPU and PPU bus events, decodes mapper register writes and
// runs the scanline interrupt counter
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  item     | in  | valid / ready | op, addr, data, scanline, display_on
//  result   | out | valid / ready | target, mapped_addr, also_main_wram,
//           |     |               | mirror_mode, irq_line
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_data (no read-back)
//
//  one transaction per clock sustained while the result side is ready; an accepted
//  item passes the input stage register, then the result register
//  the state update and translation of a staged item sit between the two
//  registers as one short combinational pass
//  arst_n clears all control state to the mapper's power-on values
//  a stalled result holds the result register; the input stage keeps
//  accepting until it also holds an item, so two transactions can be in flight
//
module cartridge_bank_mapper_scanline_irq #(
	parameter int BANK_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	cbm_in_if.sink                          item,
	cbm_out_if.source                       result
);

	logic                 valid_s1;
	cbm_pkg::cbm_item_t   item_s1;
	logic                 out_valid_q;
	cbm_pkg::cbm_result_t out_q;
	cbm_pkg::cbm_result_t res_comb;
	cbm_pkg::cbm_ctrl_t   ctrl;
	logic                 advance;
	logic                 step;
	logic [BANK_BITS-1:0] chr_banks [cbm_pkg::CHR_SLOTS];
	logic [BANK_BITS-1:0] prg_banks [cbm_pkg::PRG_WINDOWS];

	// result register moves when empty or being taken
	assign advance    = !out_valid_q || result.ready;
	// the staged item is processed (state updated) as it moves to the result
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.ready)
			valid_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op         <= cbm_pkg::op_t'(item.op);
			item_s1.addr       <= item.addr;
			item_s1.data       <= item.data;
			item_s1.scanline   <= item.scanline;
			item_s1.display_on <= item.display_on;
		end
	end

	// register file and interrupt counter
	cbm_ctrl #(
		.BANK_BITS(BANK_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (step),
		.item     (item_s1),
		.ctrl     (ctrl),
		.chr_banks(chr_banks),
		.prg_banks(prg_banks)
	);

	// translation of the staged item against the current bank state
	cbm_xlate #(
		.BANK_BITS(BANK_BITS)
	) u_xlate (
		.item     (item_s1),
		.ctrl     (ctrl),
		.chr_banks(chr_banks),
		.prg_banks(prg_banks),
		.result   (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res_comb;
	end

	assign result.valid          = out_valid_q;
	assign result.target         = out_q.target;
	assign result.mapped_addr    = out_q.mapped_addr;
	assign result.also_main_wram = out_q.also_main_wram;
	assign result.mirror_mode    = out_q.mirror_mode;
	assign result.irq_line       = out_q.irq_line;

endmodule

/* sv/cbm_ctrl.sv */
// ----------------------------------------------------------------------------
// cbm_ctrl: mapper registers and scanline interrupt counter
// decodes register writes and ticks of the staged transaction
// ----------------------------------------------------------------------------
module cbm_ctrl #(
	parameter int BANK_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              step,
	input  cbm_pkg::cbm_item_t                item,
	output cbm_pkg::cbm_ctrl_t                ctrl,
	output logic [BANK_BITS-1:0]              chr_banks [cbm_pkg::CHR_SLOTS],
	output logic [BANK_BITS-1:0]              prg_banks [cbm_pkg::PRG_WINDOWS]
);

	localparam logic [BANK_BITS-1:0] PRG2_RST = BANK_BITS'(8'hFE);
	localparam logic [BANK_BITS-1:0] PRG3_RST = BANK_BITS'(8'hFF);

	logic [7:0] prg_mask_q, chr_mask_q;
	logic       chr_is_ram_q;
	logic [7:0] bank_select_q, bank_select_d;
	logic [BANK_BITS-1:0] chr_q [cbm_pkg::CHR_SLOTS];
	logic [BANK_BITS-1:0] chr_d [cbm_pkg::CHR_SLOTS];
	logic [BANK_BITS-1:0] prg_q [cbm_pkg::PRG_WINDOWS];
	logic [BANK_BITS-1:0] prg_d [cbm_pkg::PRG_WINDOWS];
	logic [1:0] mirror_q, mirror_d;
	logic [7:0] wram_q, wram_d;
	logic [7:0] cnt_q, cnt_d, reload_q, reload_d;
	logic       on_q, on_d, pend_q, pend_d, irq_q, irq_d;
	logic [BANK_BITS-1:0] b, b_inc;
	logic       tick_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q   <= cbm_pkg::PRG_MASK_RST;
			chr_mask_q   <= cbm_pkg::CHR_MASK_RST;
			chr_is_ram_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cbm_pkg::CFG_PRG_MASK:   prg_mask_q   <= cfg_data;
				cbm_pkg::CFG_CHR_MASK:   chr_mask_q   <= cfg_data;
				cbm_pkg::CFG_CHR_IS_RAM: chr_is_ram_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign b     = item.data[BANK_BITS-1:0];
	assign b_inc = b + BANK_BITS'(1);
	assign tick_ok = (item.scanline <= cbm_pkg::LAST_VISIBLE_LINE) && item.display_on
		&& on_q && !pend_q;

	always_comb begin
		bank_select_d = bank_select_q;
		chr_d         = chr_q;
		prg_d         = prg_q;
		mirror_d      = mirror_q;
		wram_d        = wram_q;
		cnt_d         = cnt_q;
		reload_d      = reload_q;
		on_d          = on_q;
		pend_d        = pend_q;
		irq_d         = irq_q;
		if (item.op == cbm_pkg::OP_CPU_WR && item.addr[15]) begin
			case (item.addr & cbm_pkg::REG_DECODE_MASK)
				cbm_pkg::REG_BANK_SELECT: bank_select_d = item.data;
				cbm_pkg::REG_BANK_DATA: begin
					case (bank_select_q[3:0])
						cbm_pkg::SEL_CHR_PAIR_A: begin
							chr_d[0] = b;
							chr_d[1] = b_inc;
						end
						cbm_pkg::SEL_CHR_PAIR_B: begin
							chr_d[2] = b;
							chr_d[3] = b_inc;
						end
						cbm_pkg::SEL_CHR_4: chr_d[4] = b;
						cbm_pkg::SEL_CHR_5: chr_d[5] = b;
						cbm_pkg::SEL_CHR_6: chr_d[6] = b;
						cbm_pkg::SEL_CHR_7: chr_d[7] = b;
						cbm_pkg::SEL_PRG_0: prg_d[0] = b;
						cbm_pkg::SEL_PRG_1: prg_d[1] = b;
						cbm_pkg::SEL_PRG_2: prg_d[2] = b;
						cbm_pkg::SEL_PRG_3: prg_d[3] = b;
						cbm_pkg::SEL_CHR_1: chr_d[1] = b;
						cbm_pkg::SEL_CHR_3: chr_d[3] = b;
						default: ;
					endcase
				end
				cbm_pkg::REG_MIRROR:    mirror_d = item.data[1:0];
				cbm_pkg::REG_WRAM_CTRL: wram_d = item.data;
				cbm_pkg::REG_IRQ_COUNT: begin
					cnt_d  = item.data;
					pend_d = 1'b0;
				end
				cbm_pkg::REG_IRQ_RELOAD: begin
					reload_d = item.data;
					pend_d   = 1'b0;
				end
				cbm_pkg::REG_IRQ_DISABLE: begin
					on_d   = 1'b0;
					pend_d = 1'b0;
					irq_d  = 1'b0;
				end
				default: begin
					// irq enable
					on_d   = 1'b1;
					pend_d = 1'b0;
				end
			endcase
		end else if (item.op == cbm_pkg::OP_TICK && tick_ok) begin
			if (item.scanline == '0 && cnt_d != '0)
				cnt_d = cnt_d - 8'd1;
			if (cnt_d == '0) begin
				pend_d = 1'b1;
				cnt_d  = reload_q;
				irq_d  = 1'b1;
			end
			cnt_d = cnt_d - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++)
				chr_q[i] <= BANK_BITS'(i);
			prg_q[0] <= '0;
			prg_q[1] <= BANK_BITS'(1);
			prg_q[2] <= PRG2_RST;
			prg_q[3] <= PRG3_RST;
			mirror_q <= '0;
			wram_q   <= '0;
			cnt_q    <= '0;
			reload_q <= '0;
			on_q     <= 1'b0;
			pend_q   <= 1'b0;
			irq_q    <= 1'b0;
		end else if (step) begin
			bank_select_q <= bank_select_d;
			chr_q    <= chr_d;
			prg_q    <= prg_d;
			mirror_q <= mirror_d;
			wram_q   <= wram_d;
			cnt_q    <= cnt_d;
			reload_q <= reload_d;
			on_q     <= on_d;
			pend_q   <= pend_d;
			irq_q    <= irq_d;
		end
	end

	assign chr_banks = chr_q;
	assign prg_banks = prg_q;

	always_comb begin
		ctrl.bank_select = bank_select_q;
		ctrl.wram_ctrl   = wram_q;
		ctrl.chr_is_ram  = chr_is_ram_q;
		ctrl.prg_mask    = prg_mask_q;
		ctrl.chr_mask    = chr_mask_q;
		ctrl.mirror_next = mirror_d;
		ctrl.irq_next    = irq_d;
	end

endmodule

/* sv/cbm_xlate.sv */
// ----------------------------------------------------------------------------
// cbm_xlate: address translation
// maps a CPU or PPU address to a target memory and byte offset
// ----------------------------------------------------------------------------
module cbm_xlate #(
	parameter int BANK_BITS = 8
) (
	input  cbm_pkg::cbm_item_t     item,
	input  cbm_pkg::cbm_ctrl_t     ctrl,
	input  logic [BANK_BITS-1:0]   chr_banks [cbm_pkg::CHR_SLOTS],
	input  logic [BANK_BITS-1:0]   prg_banks [cbm_pkg::PRG_WINDOWS],
	output cbm_pkg::cbm_result_t   result
);

	logic [1:0] win;
	logic [2:0] slot;
	logic [7:0] prg_bank, chr_rom_bank, wram_sel;
	logic [2:0] chr_ram_bank;

	always_comb begin
		win = item.addr[14:13];
		if ((ctrl.bank_select & cbm_pkg::SEL_PRG_SWAP) != '0 && !win[0])
			win[1] = ~win[1];
		prg_bank = 8'(prg_banks[win]) & ctrl.prg_mask;

		slot = item.addr[12:10];
		if ((ctrl.bank_select & cbm_pkg::SEL_CHR_SWAP) != '0)
			slot[2] = ~slot[2];
		chr_rom_bank = 8'(chr_banks[slot]) & ctrl.chr_mask;
		// pattern RAM pairs use the pair's first bank plus one for the odd slot
		if (!slot[2])
			chr_ram_bank = chr_banks[{1'b0, slot[1], 1'b0}][2:0] + {2'b00, slot[0]};
		else
			chr_ram_bank = chr_banks[slot][2:0];

		wram_sel = ctrl.wram_ctrl & cbm_pkg::WRAM_SEL_MASK;
	end

	always_comb begin
		result.target         = cbm_pkg::TGT_NONE;
		result.mapped_addr    = '0;
		result.also_main_wram = 1'b0;
		result.mirror_mode    = ctrl.mirror_next;
		result.irq_line       = ctrl.irq_next;
		case (item.op)
			cbm_pkg::OP_CPU_WR, cbm_pkg::OP_CPU_RD: begin
				if (item.addr[15]) begin
					if (item.op == cbm_pkg::OP_CPU_RD) begin
						result.target      = cbm_pkg::TGT_PRG;
						result.mapped_addr = {prg_bank, item.addr[12:0]};
					end
				end else if (item.addr[14:13] == 2'b11) begin
					result.mapped_addr = {8'd0, item.addr[12:0]};
					if (wram_sel[7:5] == 3'b111) begin
						result.target = cbm_pkg::TGT_PAGE0 + {2'b00, wram_sel[1:0]};
						result.also_main_wram = (item.op == cbm_pkg::OP_CPU_WR)
							&& (wram_sel[1:0] == 2'b00);
					end else begin
						result.target = cbm_pkg::TGT_MAIN_WRAM;
					end
				end
			end
			cbm_pkg::OP_PPU: begin
				if (ctrl.chr_is_ram) begin
					result.target      = cbm_pkg::TGT_CHR_RAM;
					result.mapped_addr = {8'd0, chr_ram_bank, item.addr[9:0]};
				end else begin
					result.target      = cbm_pkg::TGT_CHR_ROM;
					result.mapped_addr = {3'd0, chr_rom_bank, item.addr[9:0]};
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/cbm_checker.sv */
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks of the bank mapper
// result hold under stall and consistency of result fields
// ----------------------------------------------------------------------------
module cbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  target,
	input logic [20:0] mapped_addr,
	input logic        also_main_wram
);

	// a stalled result keeps its target and offset
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mapped_addr))
		else $error("result changed while stalled");

	// no translation means a zero offset
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == cbm_pkg::TGT_NONE |-> mapped_addr == '0)
		else $error("offset without target");

	// the shadow write only happens for work RAM page 0
	a_also_page0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && also_main_wram |-> target == cbm_pkg::TGT_PAGE0)
		else $error("main work RAM shadow write outside page 0");

	// main work RAM and pattern RAM offsets stay inside the target's address space
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == cbm_pkg::TGT_MAIN_WRAM || target == cbm_pkg::TGT_CHR_RAM)
		|-> mapped_addr[20:13] == '0)
		else $error("offset out of range for work or pattern RAM");

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.target        (result.target),
	.mapped_addr   (result.mapped_addr),
	.also_main_wram(result.also_main_wram)
);

/* bench/tb_cartridge_bank_mapper_scanline_irq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_scanline_irq: self-checking bench of the bank mapper
// drives CPU, PPU and scanline transactions through the valid/ready channels,
// keeps its own copy of the mapper state to predict every translation and
// checks each result field by field, across several mask and pattern RAM
// settings, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_scanline_irq;

	localparam int         BANK_BITS  = 8;
	localparam logic [7:0] BANK_MASK  = 8'((9'd1 << BANK_BITS) - 9'd1);
	localparam logic [15:0] ROM_BASE  = 16'h8000;
	localparam logic [15:0] WRAM_BASE = 16'h6000;
	// lowest masked work RAM control value that pages the work RAM
	localparam logic [7:0] WRAM_PAGED = 8'hE0;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]                      cfg_data;

	cbm_in_if  bus_ev();
	cbm_out_if bus_xl();

	cartridge_bank_mapper_scanline_irq #(.BANK_BITS(BANK_BITS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (bus_ev),
		.result   (bus_xl)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bus events waiting to be driven, and translations still owed by the mapper
	cbm_pkg::cbm_item_t   bus_events[$];
	cbm_pkg::cbm_result_t xlat_due[$];
	int                   mismatches = 0;

	// handshake bookkeeping of the clocked processes; ev_took and idle_on are shared
	bit ev_took = 1'b0;
	bit idle_on = 1'b1;
	int src_gap = 0;
	int sink_gap = 0;

	// ------------------------------------------------------------------------
	// predicted mapper state
	// ------------------------------------------------------------------------
	logic [7:0] prg_mask, chr_mask;
	logic       chr_ram;
	logic [7:0] bank_sel;
	logic [7:0] chr_bank [0:cbm_pkg::CHR_SLOTS-1];
	logic [7:0] prg_bank [0:cbm_pkg::PRG_WINDOWS-1];
	logic [1:0] mirror;
	logic [7:0] wram_ctrl;
	logic [7:0] irq_cnt, irq_reload;
	logic       irq_en, irq_pend, irq_level;

	// applies one bus event to the predicted state and returns its translation
	function automatic cbm_pkg::cbm_result_t translate_event(cbm_pkg::cbm_item_t ev);
		cbm_pkg::cbm_result_t r;
		logic [1:0]  win;
		logic [2:0]  slot;
		logic [7:0]  bank;
		logic [7:0]  wsel;
		logic [7:0]  b;
		r = '0;
		r.target = cbm_pkg::TGT_NONE;
		b = ev.data & BANK_MASK;
		case (ev.op)
		cbm_pkg::OP_CPU_WR, cbm_pkg::OP_CPU_RD: begin
			if (ev.addr >= ROM_BASE) begin
				if (ev.op == cbm_pkg::OP_CPU_RD) begin
					// program window, first and third swap under the select bit
					win = ev.addr[14:13];
					if ((bank_sel & cbm_pkg::SEL_PRG_SWAP) != '0 && !win[0])
						win[1] = ~win[1];
					r.target = cbm_pkg::TGT_PRG;
					r.mapped_addr = {prg_bank[win] & prg_mask, ev.addr[12:0]};
				end else begin
					// register write, decoded on the top three bits and bit 0
					case (ev.addr & cbm_pkg::REG_DECODE_MASK)
					cbm_pkg::REG_BANK_SELECT: bank_sel = ev.data;
					cbm_pkg::REG_BANK_DATA: begin
						case (bank_sel[3:0])
						cbm_pkg::SEL_CHR_PAIR_A: begin
							chr_bank[0] = b;
							chr_bank[1] = (b + 8'd1) & BANK_MASK;
						end
						cbm_pkg::SEL_CHR_PAIR_B: begin
							chr_bank[2] = b;
							chr_bank[3] = (b + 8'd1) & BANK_MASK;
						end
						cbm_pkg::SEL_CHR_4: chr_bank[4] = b;
						cbm_pkg::SEL_CHR_5: chr_bank[5] = b;
						cbm_pkg::SEL_CHR_6: chr_bank[6] = b;
						cbm_pkg::SEL_CHR_7: chr_bank[7] = b;
						cbm_pkg::SEL_PRG_0: prg_bank[0] = b;
						cbm_pkg::SEL_PRG_1: prg_bank[1] = b;
						cbm_pkg::SEL_PRG_2: prg_bank[2] = b;
						cbm_pkg::SEL_PRG_3: prg_bank[3] = b;
						cbm_pkg::SEL_CHR_1: chr_bank[1] = b;
						cbm_pkg::SEL_CHR_3: chr_bank[3] = b;
						default: ;
						endcase
					end
					cbm_pkg::REG_MIRROR:     mirror = ev.data[1:0];
					cbm_pkg::REG_WRAM_CTRL:  wram_ctrl = ev.data;
					cbm_pkg::REG_IRQ_COUNT: begin
						irq_cnt = ev.data;
						irq_pend = 1'b0;
					end
					cbm_pkg::REG_IRQ_RELOAD: begin
						irq_reload = ev.data;
						irq_pend = 1'b0;
					end
					cbm_pkg::REG_IRQ_DISABLE: begin
						irq_en = 1'b0;
						irq_pend = 1'b0;
						irq_level = 1'b0;
					end
					default: begin
						irq_en = 1'b1;
						irq_pend = 1'b0;
					end
					endcase
				end
			end else if (ev.addr >= WRAM_BASE) begin
				wsel = wram_ctrl & cbm_pkg::WRAM_SEL_MASK;
				r.mapped_addr = {8'd0, ev.addr[12:0]};
				if (wsel >= WRAM_PAGED) begin
					r.target = cbm_pkg::TGT_PAGE0 + {2'b00, wsel[1:0]};
					r.also_main_wram = (ev.op == cbm_pkg::OP_CPU_WR) && (wsel == WRAM_PAGED);
				end else begin
					r.target = cbm_pkg::TGT_MAIN_WRAM;
				end
			end
		end
		cbm_pkg::OP_PPU: begin
			slot = ev.addr[12:10];
			if ((bank_sel & cbm_pkg::SEL_CHR_SWAP) != '0)
				slot[2] = ~slot[2];
			if (chr_ram) begin
				// pair slots follow the pair's first bank
				if (!slot[2])
					bank = chr_bank[{1'b0, slot[1], 1'b0}] + {7'd0, slot[0]};
				else
					bank = chr_bank[slot];
				r.target = cbm_pkg::TGT_CHR_RAM;
				r.mapped_addr = {8'd0, bank[2:0], ev.addr[9:0]};
			end else begin
				r.target = cbm_pkg::TGT_CHR_ROM;
				r.mapped_addr = {3'd0, chr_bank[slot] & chr_mask, ev.addr[9:0]};
			end
		end
		cbm_pkg::OP_TICK: begin
			if (ev.scanline <= cbm_pkg::LAST_VISIBLE_LINE && ev.display_on && irq_en
					&& !irq_pend) begin
				if (ev.scanline == 9'd0 && irq_cnt != 8'd0)
					irq_cnt = irq_cnt - 8'd1;
				if (irq_cnt == 8'd0) begin
					irq_pend = 1'b1;
					irq_cnt = irq_reload;
					irq_level = 1'b1;
				end
				irq_cnt = irq_cnt - 8'd1;
			end
		end
		default: ;
		endcase
		r.mirror_mode = mirror;
		r.irq_line = irq_level;
		return r;
	endfunction

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want_v);
		mismatches++;
		$display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h",
			$time, what, got, want_v);
	endtask

	// ------------------------------------------------------------------------
	// monitor: config shadowing, prediction on accept, result checking
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		cbm_pkg::cbm_item_t   ev;
		cbm_pkg::cbm_result_t want;
		ev_took = arst_n && bus_ev.valid && bus_ev.ready;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
				cbm_pkg::CFG_PRG_MASK:   prg_mask = cfg_data;
				cbm_pkg::CFG_CHR_MASK:   chr_mask = cfg_data;
				cbm_pkg::CFG_CHR_IS_RAM: chr_ram = cfg_data[0];
				default: ;
				endcase
			end
			// predict first so a same-edge result still sees the oldest entry
			if (ev_took) begin
				ev.op = cbm_pkg::op_t'(bus_ev.op);
				ev.addr = bus_ev.addr;
				ev.data = bus_ev.data;
				ev.scanline = bus_ev.scanline;
				ev.display_on = bus_ev.display_on;
				xlat_due.push_back(translate_event(ev));
			end
			if (bus_xl.valid && bus_xl.ready) begin
				if (xlat_due.size() == 0) begin
					flag_mismatch("result with nothing outstanding", 32'(bus_xl.target),
						32'(cbm_pkg::TGT_NONE));
				end else begin
					want = xlat_due.pop_front();
					if (bus_xl.target !== want.target)
						flag_mismatch("target", 32'(bus_xl.target), 32'(want.target));
					if (bus_xl.mapped_addr !== want.mapped_addr)
						flag_mismatch("mapped_addr", 32'(bus_xl.mapped_addr),
							32'(want.mapped_addr));
					if (bus_xl.also_main_wram !== want.also_main_wram)
						flag_mismatch("also_main_wram", 32'(bus_xl.also_main_wram),
							32'(want.also_main_wram));
					if (bus_xl.mirror_mode !== want.mirror_mode)
						flag_mismatch("mirror_mode", 32'(bus_xl.mirror_mode),
							32'(want.mirror_mode));
					if (bus_xl.irq_line !== want.irq_line)
						flag_mismatch("irq_line", 32'(bus_xl.irq_line), 32'(want.irq_line));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// driver: next event once the current transaction is taken, with gap bursts
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : driver
		cbm_pkg::cbm_item_t nxt;
		if (arst_n && (!bus_ev.valid || ev_took)) begin
			if (src_gap != 0) begin
				src_gap--;
				bus_ev.valid <= 1'b0;
			end else if (bus_events.size() != 0) begin
				nxt = bus_events.pop_front();
				bus_ev.op <= nxt.op;
				bus_ev.addr <= nxt.addr;
				bus_ev.data <= nxt.data;
				bus_ev.scanline <= nxt.scanline;
				bus_ev.display_on <= nxt.display_on;
				bus_ev.valid <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					src_gap = $urandom_range(1, 18);
			end else begin
				bus_ev.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, random stall bursts
	always @(negedge clk) begin
		if (sink_gap != 0) begin
			sink_gap--;
			bus_xl.ready <= 1'b0;
		end else begin
			bus_xl.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 11) == 0)
				sink_gap = $urandom_range(1, 18);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_ev(cbm_pkg::op_t op, logic [15:0] a, logic [7:0] d,
			logic [8:0] line, logic disp);
		cbm_pkg::cbm_item_t ev;
		ev.op = op;
		ev.addr = a;
		ev.data = d;
		ev.scanline = line;
		ev.display_on = disp;
		bus_events.push_back(ev);
	endtask

	// random scanline number and random flag
	function automatic logic [8:0] rnd_line();
		return 9'($urandom_range(0, 261));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// register address with random don't-care bits around the decoded ones
	function automatic logic [15:0] reg_at(logic [15:0] base);
		logic [15:0] noise;
		noise = 16'($urandom);
		return (noise & ~cbm_pkg::REG_DECODE_MASK) | base;
	endfunction

	task automatic queue_random(int n);
		int         made;
		int         kind;
		int         k;
		logic [8:0] line;
		logic [7:0] sel;
		logic [15:0] a;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				// bank select then bank data, mostly on the defined select codes
				sel = 8'($urandom);
				if ($urandom_range(0, 7) != 0)
					sel[3:0] = 4'($urandom_range(cbm_pkg::SEL_CHR_PAIR_A, cbm_pkg::SEL_CHR_3));
				push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_BANK_SELECT), sel,
					rnd_line(), rnd_bit());
				push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_BANK_DATA), 8'($urandom),
					rnd_line(), rnd_bit());
				made += 2;
			end else if (kind < 30) begin
				sel = 8'($urandom);
				if ($urandom_range(0, 1)) begin
					push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_MIRROR), sel,
						rnd_line(), rnd_bit());
				end else begin
					// mostly paged work RAM settings
					if ($urandom_range(0, 2) != 0)
						sel[7:5] = 3'b111;
					push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_WRAM_CTRL), sel,
						rnd_line(), rnd_bit());
				end
				made++;
			end else if (kind < 45) begin
				if ($urandom_range(0, 1)) begin
					a = 16'($urandom_range(WRAM_BASE, 16'hFFFF));
					push_ev(cbm_pkg::OP_CPU_RD, a, 8'($urandom), rnd_line(), rnd_bit());
				end else begin
					a = 16'($urandom_range(WRAM_BASE, ROM_BASE - 16'd1));
					push_ev(cbm_pkg::OP_CPU_WR, a, 8'($urandom), rnd_line(), rnd_bit());
				end
				made++;
			end else if (kind < 50) begin
				// noise: anything at all, low CPU space and stray register writes too
				push_ev(cbm_pkg::op_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
					rnd_line(), rnd_bit());
				made++;
			end else if (kind < 68) begin
				push_ev(cbm_pkg::OP_PPU, 16'($urandom), 8'($urandom), rnd_line(), rnd_bit());
				made++;
			end else if (kind < 78) begin
				// interrupt setup: small reload and count, then mostly enable
				push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_IRQ_RELOAD),
					8'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8)),
					rnd_line(), rnd_bit());
				push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_IRQ_COUNT),
					8'($urandom_range(0, 6)), rnd_line(), rnd_bit());
				push_ev(cbm_pkg::OP_CPU_WR, ($urandom_range(0, 3) == 0)
					? reg_at(cbm_pkg::REG_IRQ_DISABLE)
					: reg_at(cbm_pkg::REG_IRQ_DISABLE | 16'h0001), 8'($urandom),
					rnd_line(), rnd_bit());
				made += 3;
			end else begin
				// a run of consecutive scanlines, sometimes from the top of the frame
				k = $urandom_range(1, 12);
				line = ($urandom_range(0, 2) == 0) ? 9'd0 : rnd_line();
				for (int i = 0; i < k; i++) begin
					push_ev(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom), line,
						$urandom_range(0, 9) != 0);
					line = (line == 9'd261) ? 9'd0 : line + 9'd1;
				end
				made += k;
				// acknowledge by rewriting the counter, now and then drop the line
				if ($urandom_range(0, 2) == 0) begin
					push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_IRQ_COUNT),
						8'($urandom_range(0, 6)), rnd_line(), rnd_bit());
					made++;
				end
				if ($urandom_range(0, 5) == 0) begin
					push_ev(cbm_pkg::OP_CPU_WR, reg_at(cbm_pkg::REG_IRQ_DISABLE), 8'($urandom),
						rnd_line(), rnd_bit());
					made++;
				end
			end
		end
	endtask

	// hold the sender until the mapper is empty, then load a new setting
	task automatic next_setting(logic [7:0] prg, logic [7:0] chr, logic ram);
		while (bus_events.size() != 0 || bus_ev.valid || xlat_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= cbm_pkg::CFG_PRG_MASK;
		cfg_data <= prg;
		@(negedge clk);
		cfg_index <= cbm_pkg::CFG_CHR_MASK;
		cfg_data <= chr;
		@(negedge clk);
		cfg_index <= cbm_pkg::CFG_CHR_IS_RAM;
		cfg_data <= {7'd0, ram};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bus_ev.valid = 1'b0;
		bus_ev.op = cbm_pkg::OP_CPU_WR;
		bus_ev.addr = '0;
		bus_ev.data = '0;
		bus_ev.scanline = '0;
		bus_ev.display_on = 1'b0;
		bus_xl.ready = 1'b0;

		// power-on state of the mapper
		prg_mask = cbm_pkg::PRG_MASK_RST;
		chr_mask = cbm_pkg::CHR_MASK_RST;
		chr_ram = 1'b0;
		bank_sel = '0;
		for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++)
			chr_bank[i] = 8'(i) & BANK_MASK;
		prg_bank[0] = 8'h00;
		prg_bank[1] = 8'h01;
		prg_bank[2] = 8'hFE & BANK_MASK;
		prg_bank[3] = 8'hFF & BANK_MASK;
		mirror = '0;
		wram_ctrl = '0;
		irq_cnt = '0;
		irq_reload = '0;
		irq_en = 1'b0;
		irq_pend = 1'b0;
		irq_level = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: program windows, address space edges
		push_ev(cbm_pkg::OP_CPU_RD, 16'h8000, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_RD, 16'hFFFF, 8'hFF, 9'd261, 1'b1);
		push_ev(cbm_pkg::OP_CPU_RD, 16'hA123, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_RD, 16'hC000, 8'h00, 9'd0, 1'b0);
		// low CPU space, the 0x5000 area among it
		push_ev(cbm_pkg::OP_CPU_RD, 16'h0000, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'h5000, 8'hFF, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_RD, 16'h6000, 8'h00, 9'd0, 1'b0);
		// pattern fetches, high address bits ignored
		push_ev(cbm_pkg::OP_PPU, 16'hFFFF, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_PPU, 16'h0000, 8'h00, 9'd0, 1'b0);
		// both swaps on, unused select code swallows the data write
		push_ev(cbm_pkg::OP_CPU_WR, 16'h8000, 8'hFF, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'h8001, 8'hFF, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_RD, 16'h8000, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_PPU, 16'h0400, 8'h00, 9'd0, 1'b0);
		// mirroring and work RAM paging, page 0 write also lands in main RAM
		push_ev(cbm_pkg::OP_CPU_WR, 16'hA000, 8'hFF, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'hA001, 8'hE0, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'h7FFF, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'hA001, 8'hFF, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_RD, 16'h6000, 8'h00, 9'd0, 1'b0);
		// interrupt: reload, enable, fire on line 0, then ignored ticks
		push_ev(cbm_pkg::OP_CPU_WR, 16'hC001, 8'h01, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'hFFFF, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
		push_ev(cbm_pkg::OP_TICK, 16'h0000, 8'h00, 9'd240, 1'b1);
		push_ev(cbm_pkg::OP_CPU_WR, 16'hC000, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_TICK, 16'h0000, 8'h00, 9'd5, 1'b0);
		push_ev(cbm_pkg::OP_CPU_WR, 16'hE000, 8'h00, 9'd0, 1'b0);
		push_ev(cbm_pkg::OP_TICK, 16'hFFFF, 8'hFF, 9'd261, 1'b1);

		queue_random(110);
		next_setting(8'd1, 8'd0, 1'b0);
		queue_random(130);
		next_setting(8'd255, 8'd255, 1'b1);
		queue_random(130);
		next_setting(8'd15, 8'd31, 1'b1);
		queue_random(130);
		next_setting(8'd255, 8'd0, 1'b0);
		queue_random(130);
		// last stretch at full rate on both sides
		idle_on = 1'b0;
		next_setting(8'd7, 8'd127, 1'b0);
		queue_random(130);

		while (bus_events.size() != 0 || bus_ev.valid)
			@(posedge clk);
		for (int w = 0; w < 200 && xlat_due.size() != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (xlat_due.size() != 0)
			flag_mismatch("results never delivered", 0, xlat_due.size());
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
